@@ rtl/cbvb_pkg.sv @@
`default_nettype none

package cbvb_pkg;

    localparam int DET_COLS    = 1024;
    localparam int DET_ROWS    = 64;
    localparam int STORE_DEPTH = DET_COLS * DET_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(DET_COLS);
    localparam int ROW_W       = $clog2(DET_ROWS);

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W  = 64;

    localparam int CORDIC_STEPS   = 28;
    localparam int CORDIC_IDX_W   = $clog2(CORDIC_STEPS);
    localparam int CORDIC_GAIN_Q30 = 652032875;
    localparam int TWO_PI_Q44      = 1686629713;
    localparam int FINAL_SCALE_Q32 = 3022022;

    localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'shFFFF_8000_0000_0000;

    localparam logic [1:0] CMD_LOAD        = 2'd0;
    localparam logic [1:0] CMD_BACKPROJECT = 2'd1;
    localparam logic [1:0] CMD_FINALIZE    = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_DIST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_CENTER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_CENTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_LIMIT_SQ = 3'd6;

    function automatic logic signed [31:0] atan_q28(input logic [CORDIC_IDX_W-1:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd210828714;
            5'd1:  r = 32'sd124459457;
            5'd2:  r = 32'sd65760959;
            5'd3:  r = 32'sd33381290;
            5'd4:  r = 32'sd16755422;
            5'd5:  r = 32'sd8385879;
            5'd6:  r = 32'sd4193963;
            5'd7:  r = 32'sd2097109;
            5'd8:  r = 32'sd1048571;
            5'd9:  r = 32'sd524287;
            5'd10: r = 32'sd262144;
            5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;
            5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;
            5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;
            5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;
            5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;
            5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;
            5'd23: r = 32'sd32;
            5'd24: r = 32'sd16;
            5'd25: r = 32'sd8;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbvb_store.sv @@
`default_nettype none

module cbvb_store import cbvb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [31:0]       i_wdata,
    output logic      [31:0]       o_rdata
);

    logic [31:0] r_mem [STORE_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/cbvb_mul.sv @@
`default_nettype none

module cbvb_mul import cbvb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic      signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/cbvb_div.sv @@
`default_nettype none

module cbvb_div import cbvb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quot
);

    logic [DIV_W-1:0]         r_quot;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_divisor;
    logic [$clog2(DIV_W)-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [DIV_W:0]           w_shift;
    logic [DIV_W:0]           w_diff;
    logic                     w_ge;

    assign w_shift = {r_rem, r_quot[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_divisor};
    assign w_ge    = w_shift >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_quot    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DIV_W))'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ rtl/cone_beam_voxel_backprojector.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    command, det_col/row, sample, x/y/z, angle, sum
// output    out        o_out_valid / i_out_ready  accum_out, inside_fov, tap_hit
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
// The work of a backproject is set by two 28-step CORDIC passes on the shared add/shift
// unit, a 32-step square root, two 64-step divisions in the divider, and 20 passes
// through the shared multiplier.
// Synchronous active-low reset; the sample store has no clear and needs no sweep.
// A result waiting in the output register stalls only the end of the next item.
`default_nettype none

module cone_beam_voxel_backprojector import cbvb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_command,
    input  wire logic [9:0]            i_det_col,
    input  wire logic [5:0]            i_det_row,
    input  wire logic signed [31:0]    i_sample_value,
    input  wire logic signed [31:0]    i_x_coord,
    input  wire logic signed [31:0]    i_y_coord,
    input  wire logic signed [31:0]    i_z_coord,
    input  wire logic [15:0]           i_view_angle,
    input  wire logic signed [47:0]    i_accum_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [47:0]         o_accum_out,
    output logic                       o_inside_fov,
    output logic                       o_tap_hit
);

    typedef enum logic [5:0] {
        S_IDLE, S_FOV_A, S_FOV_B, S_FOV_C, S_FIN_A, S_FIN_B, S_FIN_C,
        S_SC_Z, S_SC_Z1, S_SC_IT, S_SC_Q, S_GEO_A, S_GEO_B, S_GEO_C,
        S_GEO_D, S_GEO_E, S_GEO_F, S_SQ_IT, S_DOT_A, S_DOT_B, S_DOT_C,
        S_NUM_B, S_NUM_C, S_AT_IT, S_U_A, S_U_B, S_U_C, S_DIVQ_W,
        S_V_A, S_V_B, S_RANGE, S_RD1, S_RD2, S_RD3, S_RD4, S_RD5,
        S_RD6, S_RD7, S_DIVC_W, S_OUT
    } t_state;

    function automatic logic [32:0] mag32(input logic signed [31:0] v);
        return v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic drow, input logic dcol);
        return ADDR_W'((32'(row) + 32'(drow)) * 32'(DET_COLS) + 32'(col) + 32'(dcol));
    endfunction

    t_state                    r_state;
    logic [31:0]               r_scan_radius, r_det_dist, r_col_scale, r_row_scale;
    logic signed [31:0]        r_col_center, r_row_center;
    logic [31:0]               r_fov_limit_sq;

    logic [1:0]                r_cmd;
    logic signed [31:0]        r_x, r_y, r_z;
    logic [15:0]               r_ang;
    logic signed [47:0]        r_acc;

    logic signed [63:0]        r_t;
    logic signed [63:0]        r_cx, r_cy;
    logic signed [31:0]        r_cz;
    logic [CORDIC_IDX_W-1:0]   r_i;
    logic signed [MUL_W-1:0]   r_cs, r_sn;
    logic [MUL_W-1:0]          r_ax, r_ay;
    logic                      r_sh;
    logic [63:0]               r_n, r_sq, r_bit, r_d;
    logic [63:0]               r_depth;
    logic [MUL_W-1:0]          r_depth16;
    logic signed [63:0]        r_u, r_v;
    logic signed [31:0]        r_vq;
    logic signed [MUL_W-1:0]   r_alo, r_ahi;
    logic                      r_p_neg;

    logic                      r_out_valid;
    logic signed [47:0]        r_accum_out;
    logic                      r_inside_fov, r_tap_hit;
    logic signed [47:0]        r_res;
    logic                      r_res_inside, r_res_hit;

    logic                      w_in_acc;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [63:0]        w_prod64;
    logic signed [63:0]        w_sum, w_tdiff;
    logic [31:0]               w_rdata;
    logic                      w_mem_we;
    logic [ADDR_W-1:0]         w_mem_addr;
    logic                      w_div_start, w_div_done;
    logic [DIV_W-1:0]          w_dividend, w_divisor, w_quot;

    logic                      w_dir;
    logic signed [63:0]        w_cx_n, w_cy_n;
    logic signed [31:0]        w_cz_n;
    logic [63:0]               w_trial;
    logic                      w_ge;
    logic [63:0]               w_dmag;
    logic signed [63:0]        w_dot;
    logic [63:0]               w_depth;
    logic [47:0]               w_accmag;
    logic [63:0]               w_fin_r;
    logic signed [63:0]        w_ucol, w_vrow;
    logic                      w_range_ok;
    logic [ROW_W-1:0]          w_row;
    logic [COL_W-1:0]          w_col;
    logic [16:0]               w_wv_lo, w_wu_lo;
    logic signed [63:0]        w_p;
    logic [31:0]               w_qmag;
    logic signed [63:0]        w_contrib, w_acc_sum;
    logic signed [47:0]        w_sat;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_prod64 = $signed(w_prod[63:0]);
    assign w_sum    = r_t + w_prod64;
    assign w_tdiff  = r_t - w_prod64;

    // shared CORDIC step: rotation follows z, vectoring follows y
    assign w_dir  = (r_state == S_SC_IT) ? !r_cz[31] : r_cy[63];
    assign w_cx_n = w_dir ? (r_cx - (r_cy >>> r_i)) : (r_cx + (r_cy >>> r_i));
    assign w_cy_n = w_dir ? (r_cy + (r_cx >>> r_i)) : (r_cy - (r_cx >>> r_i));
    assign w_cz_n = w_dir ? (r_cz - atan_q28(r_i)) : (r_cz + atan_q28(r_i));

    assign w_trial = r_sq + r_bit;
    assign w_ge    = r_n >= w_trial;

    assign w_dmag  = mag64(64'((r_state == S_GEO_B) ? r_x : r_y) - (w_prod64 >>> 30));
    assign w_dot   = w_sum - $signed({2'b00, r_scan_radius, 30'd0});
    assign w_depth = mag64(w_dot);

    assign w_accmag = r_acc[47] ? (48'd0 - r_acc) : r_acc;
    assign w_fin_r  = ($unsigned(r_t) >> 8)
                    + (((($unsigned(r_t) & 64'hFF) << 24) + $unsigned(w_prod64)) >> 32);

    assign w_ucol     = r_u >>> 16;
    assign w_vrow     = r_v >>> 16;
    assign w_range_ok = !w_ucol[63] && (w_ucol <= 64'(DET_COLS - 2))
                     && !w_vrow[63] && (w_vrow <= 64'(DET_ROWS - 2));
    assign w_col      = w_ucol[COL_W-1:0];
    assign w_row      = w_vrow[ROW_W-1:0];
    assign w_wv_lo    = 17'h10000 - {1'b0, r_v[15:0]};
    assign w_wu_lo    = 17'h10000 - {1'b0, r_u[15:0]};
    assign w_p        = w_sum >>> 16;

    assign w_qmag    = (w_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : {1'b0, w_quot[30:0]};
    assign w_contrib = r_p_neg ? (64'sd0 - $signed(w_quot)) : $signed(w_quot);
    assign w_acc_sum = 64'(r_acc) + w_contrib;
    assign w_sat     = (w_acc_sum > SUM_MAX) ? 48'(SUM_MAX) :
                       (w_acc_sum < SUM_MIN) ? 48'(SUM_MIN) : 48'(w_acc_sum);

    assign w_div_start = (r_state == S_U_C) || (r_state == S_RD7);
    assign w_dividend  = (r_state == S_U_C) ? $unsigned(w_prod64) : (mag64(w_p) << 16);
    assign w_divisor   = (r_state == S_U_C) ? 64'(r_depth16) : r_d;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_FOV_A: begin
                w_mul_a = {1'b0, mag32(r_x)};
                w_mul_b = {1'b0, mag32(r_x)};
            end
            S_FOV_B: begin
                w_mul_a = {1'b0, mag32(r_y)};
                w_mul_b = {1'b0, mag32(r_y)};
            end
            S_FIN_A: begin
                w_mul_a = {10'd0, w_accmag[47:24]};
                w_mul_b = MUL_W'(FINAL_SCALE_Q32);
            end
            S_FIN_B: begin
                w_mul_a = {10'd0, w_accmag[23:0]};
                w_mul_b = MUL_W'(FINAL_SCALE_Q32);
            end
            S_SC_Z: begin
                w_mul_a = {20'd0, r_ang[13:0]};
                w_mul_b = MUL_W'(TWO_PI_Q44);
            end
            S_GEO_A: begin
                w_mul_a = {2'b00, r_scan_radius};
                w_mul_b = r_cs;
            end
            S_GEO_B: begin
                w_mul_a = {2'b00, r_scan_radius};
                w_mul_b = r_sn;
            end
            S_GEO_D: begin
                w_mul_a = r_ax;
                w_mul_b = r_ax;
            end
            S_GEO_E: begin
                w_mul_a = r_ay;
                w_mul_b = r_ay;
            end
            S_DOT_A: begin
                w_mul_a = MUL_W'(r_x);
                w_mul_b = r_cs;
            end
            S_DOT_B: begin
                w_mul_a = MUL_W'(r_y);
                w_mul_b = r_sn;
            end
            S_DOT_C: begin
                w_mul_a = MUL_W'(r_x);
                w_mul_b = r_sn;
            end
            S_NUM_B: begin
                w_mul_a = MUL_W'(r_y);
                w_mul_b = r_cs;
            end
            S_U_A: begin
                w_mul_a = MUL_W'(0) - MUL_W'(r_cz);
                w_mul_b = {2'b00, r_col_scale};
            end
            S_U_B: begin
                w_mul_a = {1'b0, mag32(r_z)};
                w_mul_b = {2'b00, r_det_dist};
            end
            S_V_A: begin
                w_mul_a = MUL_W'(r_vq);
                w_mul_b = {2'b00, r_row_scale};
            end
            S_RD1, S_RD3: begin
                w_mul_a = MUL_W'($signed(w_rdata));
                w_mul_b = {17'd0, w_wv_lo};
            end
            S_RD2, S_RD4: begin
                w_mul_a = MUL_W'($signed(w_rdata));
                w_mul_b = {18'd0, r_v[15:0]};
            end
            S_RD5: begin
                w_mul_a = r_alo;
                w_mul_b = {17'd0, w_wu_lo};
            end
            S_RD6: begin
                w_mul_a = r_ahi;
                w_mul_b = {18'd0, r_u[15:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_addr = addr_of(w_row, w_col, 1'b0, 1'b0);
        case (r_state)
            S_IDLE: begin
                w_mem_we   = w_in_acc && (i_command == CMD_LOAD)
                          && (32'(i_det_col) < 32'(DET_COLS))
                          && (32'(i_det_row) < 32'(DET_ROWS));
                w_mem_addr = ADDR_W'(32'(i_det_row) * 32'(DET_COLS) + 32'(i_det_col));
            end
            S_RD1:   w_mem_addr = addr_of(w_row, w_col, 1'b1, 1'b0);
            S_RD2:   w_mem_addr = addr_of(w_row, w_col, 1'b0, 1'b1);
            S_RD3:   w_mem_addr = addr_of(w_row, w_col, 1'b1, 1'b1);
            default: w_mem_addr = addr_of(w_row, w_col, 1'b0, 1'b0);
        endcase
    end

    cbvb_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (i_sample_value),
        .o_rdata (w_rdata)
    );

    cbvb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    cbvb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_scan_radius  <= 32'd0;
            r_det_dist     <= 32'd0;
            r_col_scale    <= 32'd65536;
            r_row_scale    <= 32'd65536;
            r_col_center   <= 32'sd0;
            r_row_center   <= 32'sd0;
            r_fov_limit_sq <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCAN_RADIUS:  r_scan_radius  <= i_cfg_data;
                    CFG_DET_DIST:     r_det_dist     <= i_cfg_data;
                    CFG_COL_SCALE:    r_col_scale    <= i_cfg_data;
                    CFG_ROW_SCALE:    r_row_scale    <= i_cfg_data;
                    CFG_COL_CENTER:   r_col_center   <= i_cfg_data;
                    CFG_ROW_CENTER:   r_row_center   <= i_cfg_data;
                    CFG_FOV_LIMIT_SQ: r_fov_limit_sq <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd <= i_command;
                        r_x   <= i_x_coord;
                        r_y   <= i_y_coord;
                        r_z   <= i_z_coord;
                        r_ang <= i_view_angle;
                        r_acc <= i_accum_in;
                        if (i_command == CMD_BACKPROJECT || i_command == CMD_FINALIZE) begin
                            r_state <= S_FOV_A;
                        end
                    end
                end
                S_FOV_A: r_state <= S_FOV_B;
                S_FOV_B: begin
                    r_t     <= w_prod64;
                    r_state <= S_FOV_C;
                end
                S_FOV_C: begin
                    r_res     <= r_acc;
                    r_res_hit <= 1'b0;
                    if ($unsigned(w_sum) < 64'({r_fov_limit_sq, 16'd0})) begin
                        r_res_inside <= 1'b1;
                        r_state <= (r_cmd == CMD_FINALIZE) ? S_FIN_A : S_SC_Z;
                    end else begin
                        r_res_inside <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_FIN_A: r_state <= S_FIN_B;
                S_FIN_B: begin
                    r_t     <= w_prod64;
                    r_state <= S_FIN_C;
                end
                S_FIN_C: begin
                    r_res   <= r_acc[47] ? 48'(w_fin_r) : 48'(64'd0 - w_fin_r);
                    r_state <= S_OUT;
                end
                S_SC_Z: r_state <= S_SC_Z1;
                S_SC_Z1: begin
                    r_cz    <= 32'(w_prod64 >>> 16);
                    r_cx    <= 64'(CORDIC_GAIN_Q30);
                    r_cy    <= 64'sd0;
                    r_i     <= '0;
                    r_state <= S_SC_IT;
                end
                S_SC_IT: begin
                    r_cx <= w_cx_n;
                    r_cy <= w_cy_n;
                    r_cz <= w_cz_n;
                    r_i  <= r_i + 1'b1;
                    if (r_i == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_SC_Q;
                    end
                end
                S_SC_Q: begin
                    case (r_ang[15:14])
                        2'd0: begin
                            r_cs <= MUL_W'(r_cx);
                            r_sn <= MUL_W'(r_cy);
                        end
                        2'd1: begin
                            r_cs <= MUL_W'(64'sd0 - r_cy);
                            r_sn <= MUL_W'(r_cx);
                        end
                        2'd2: begin
                            r_cs <= MUL_W'(64'sd0 - r_cx);
                            r_sn <= MUL_W'(64'sd0 - r_cy);
                        end
                        default: begin
                            r_cs <= MUL_W'(r_cy);
                            r_sn <= MUL_W'(64'sd0 - r_cx);
                        end
                    endcase
                    r_state <= S_GEO_A;
                end
                S_GEO_A: r_state <= S_GEO_B;
                S_GEO_B: begin
                    r_ax    <= MUL_W'(w_dmag);
                    r_state <= S_GEO_C;
                end
                S_GEO_C: begin
                    if (r_ax[MUL_W-1:31] != '0 || w_dmag[MUL_W-1:31] != '0) begin
                        r_sh <= 1'b1;
                        r_ax <= r_ax >> 2;
                        r_ay <= MUL_W'(w_dmag >> 2);
                    end else begin
                        r_sh <= 1'b0;
                        r_ay <= MUL_W'(w_dmag);
                    end
                    r_state <= S_GEO_D;
                end
                S_GEO_D: r_state <= S_GEO_E;
                S_GEO_E: begin
                    r_t     <= w_prod64;
                    r_state <= S_GEO_F;
                end
                S_GEO_F: begin
                    r_n     <= $unsigned(w_sum);
                    r_sq    <= 64'd0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_state <= S_SQ_IT;
                end
                S_SQ_IT: begin
                    if (w_ge) begin
                        r_n  <= r_n - w_trial;
                        r_sq <= (r_sq >> 1) + r_bit;
                    end else begin
                        r_sq <= r_sq >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_DOT_A;
                    end
                end
                S_DOT_A: begin
                    r_d     <= r_sh ? (r_sq << 2) : r_sq;
                    r_state <= S_DOT_B;
                end
                S_DOT_B: begin
                    r_t     <= w_prod64;
                    r_state <= S_DOT_C;
                end
                S_DOT_C: begin
                    r_depth   <= w_depth;
                    r_depth16 <= MUL_W'(w_depth >> 30);
                    if ((w_depth >> 30) == 64'd0 || r_d == 64'd0) begin
                        r_res_hit <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_NUM_B;
                    end
                end
                S_NUM_B: begin
                    r_t     <= w_prod64;
                    r_state <= S_NUM_C;
                end
                S_NUM_C: begin
                    r_cx    <= $signed(r_depth >> 4);
                    r_cy    <= w_tdiff >>> 4;
                    r_cz    <= 32'sd0;
                    r_i     <= '0;
                    r_state <= S_AT_IT;
                end
                S_AT_IT: begin
                    r_cx <= w_cx_n;
                    r_cy <= w_cy_n;
                    r_cz <= w_cz_n;
                    r_i  <= r_i + 1'b1;
                    if (r_i == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_U_A;
                    end
                end
                S_U_A: r_state <= S_U_B;
                S_U_B: begin
                    r_u     <= (w_prod64 >>> 28) + 64'(r_col_center);
                    r_state <= S_U_C;
                end
                S_U_C: r_state <= S_DIVQ_W;
                S_DIVQ_W: begin
                    if (w_div_done) begin
                        r_vq    <= r_z[31] ? $signed(w_qmag) : $signed(32'd0 - w_qmag);
                        r_state <= S_V_A;
                    end
                end
                S_V_A: r_state <= S_V_B;
                S_V_B: begin
                    r_v     <= (w_prod64 >>> 16) + 64'(r_row_center);
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    if (w_range_ok) begin
                        r_state <= S_RD1;
                    end else begin
                        r_res_hit <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    r_t     <= w_prod64;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_alo   <= MUL_W'(w_sum >>> 16);
                    r_state <= S_RD4;
                end
                S_RD4: begin
                    r_t     <= w_prod64;
                    r_state <= S_RD5;
                end
                S_RD5: begin
                    r_ahi   <= MUL_W'(w_sum >>> 16);
                    r_state <= S_RD6;
                end
                S_RD6: begin
                    r_t     <= w_prod64;
                    r_state <= S_RD7;
                end
                S_RD7: begin
                    r_p_neg <= w_p[63];
                    r_state <= S_DIVC_W;
                end
                S_DIVC_W: begin
                    if (w_div_done) begin
                        r_res     <= w_sat;
                        r_res_hit <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_accum_out  <= r_res;
                        r_inside_fov <= r_res_inside;
                        r_tap_hit    <= r_res_hit;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_accum_out  = r_accum_out;
    assign o_inside_fov = r_inside_fov;
    assign o_tap_hit    = r_tap_hit;

endmodule

`default_nettype wire

@@ bench/tb_cone_beam_voxel_backprojector.sv @@
`timescale 1ns / 100ps

module tb_cone_beam_voxel_backprojector;
    import cbvb_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [1:0]          cmd;
        logic [9:0]          col;
        logic [5:0]          row;
        logic signed [31:0]  sample;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  z;
        logic [15:0]         angle;
        logic signed [47:0]  accum;
    } voxel_item_t;

    typedef struct {
        logic signed [47:0] accum;
        logic               in_fov;
        logic               hit;
    } voxel_sum_t;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_command = CMD_LOAD;
    logic [9:0]            i_det_col = '0;
    logic [5:0]            i_det_row = '0;
    logic signed [31:0]    i_sample_value = '0;
    logic signed [31:0]    i_x_coord = '0;
    logic signed [31:0]    i_y_coord = '0;
    logic signed [31:0]    i_z_coord = '0;
    logic [15:0]           i_view_angle = '0;
    logic signed [47:0]    i_accum_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [47:0]    o_accum_out;
    logic                  o_inside_fov;
    logic                  o_tap_hit;

    cone_beam_voxel_backprojector uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [31:0] geo [7];
    int          proj [STORE_DEPTH];
    bit          written [STORE_DEPTH];
    longint      atan_tab [28] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    voxel_item_t pending_items [$];
    voxel_sum_t  sums_due [$];
    int          errors = 0;
    longint      cycles = 0;
    bit          in_took = 1'b0;

    function automatic u64_t magn(longint v);
        if (v < 0) return -v;
        return v;
    endfunction

    function automatic u64_t int_sqrt(u64_t n);
        u64_t res = 0;
        u64_t b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void turn_sincos(input logic [15:0] ang, output longint cs,
                                        output longint sn);
        longint x, y, z, nx;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = longint'((u64_t'(ang[13:0]) * u64_t'(TWO_PI_Q44)) >> 16);
        for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
            end
            x = nx;
        end
        case (ang[15:14])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic longint fan_atan(longint x, longint y);
        longint z, nx;
        z = 0;
        x = x >>> 4;
        y = y >>> 4;
        for (int i = 0; i < 28; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint scale_final(longint a);
        u64_t m, ah, al, p1, p0, r;
        m = magn(a);
        ah = m >> 24;
        al = m & 64'hFF_FFFF;
        p1 = ah * FINAL_SCALE_Q32;
        p0 = al * FINAL_SCALE_Q32;
        r = (p1 >> 8) + ((((p1 & 64'hFF) << 24) + p0) >> 32);
        if (a < 0) return r;
        return -longint'(r);
    endfunction

    function automatic bit predict_voxel(input voxel_item_t it, output voxel_sum_t r,
                                         output bit reads, output int base);
        longint x, y, z, acc, res, contrib, cs, sn, sxp, syp, dot, depth, num, angq;
        longint u, v, vq, ucol, vrow, alo, ahi, p, fu, fv;
        longint rad, ddist, cscale, rscale, ccen, rcen;
        longint s00, s01, s10, s11;
        u64_t ax, ay, d, depth16, qmag, cm, r2;
        int sh;
        bit in_fov, hit;
        reads = 0;
        base = 0;
        hit = 0;
        r = '{default: '0};
        if (it.cmd == CMD_LOAD || it.cmd == CMD_UNUSED) return 0;
        x = it.x; y = it.y; z = it.z; acc = it.accum;
        rad = geo[CFG_SCAN_RADIUS];
        ddist = geo[CFG_DET_DIST];
        cscale = geo[CFG_COL_SCALE];
        rscale = geo[CFG_ROW_SCALE];
        ccen = $signed(geo[CFG_COL_CENTER]);
        rcen = $signed(geo[CFG_ROW_CENTER]);
        res = acc;
        r2 = magn(x) * magn(x) + magn(y) * magn(y);
        in_fov = r2 < (u64_t'(geo[CFG_FOV_LIMIT_SQ]) << 16);
        if (in_fov && it.cmd == CMD_BACKPROJECT) begin
            turn_sincos(it.angle, cs, sn);
            sxp = (rad * cs) >>> 30;
            syp = (rad * sn) >>> 30;
            ax = magn(x - sxp);
            ay = magn(y - syp);
            sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 2 : 0;
            ax >>= sh;
            ay >>= sh;
            d = int_sqrt(ax * ax + ay * ay) << sh;
            dot = x * cs + y * sn - (rad <<< 30);
            depth = (dot < 0) ? -dot : dot;
            depth16 = u64_t'(depth) >> 30;
            if (depth16 != 0 && d != 0) begin
                num = x * sn - y * cs;
                angq = -fan_atan(depth, num);
                u = ((angq * cscale) >>> 28) + ccen;
                qmag = (magn(z) * u64_t'(ddist)) / depth16;
                if (qmag > 64'h7FFF_FFFF) qmag = 64'h7FFF_FFFF;
                if (z < 0) vq = qmag;
                else vq = -longint'(qmag);
                v = ((vq * rscale) >>> 16) + rcen;
                ucol = u >>> 16;
                vrow = v >>> 16;
                if (ucol >= 0 && ucol + 1 < DET_COLS && vrow >= 0 && vrow + 1 < DET_ROWS) begin
                    reads = 1;
                    base = vrow * DET_COLS + ucol;
                    fu = u & 64'hFFFF;
                    fv = v & 64'hFFFF;
                    s00 = proj[base];
                    s01 = proj[base + DET_COLS];
                    s10 = proj[base + 1];
                    s11 = proj[base + DET_COLS + 1];
                    alo = (s00 * (65536 - fv) + s01 * fv) >>> 16;
                    ahi = (s10 * (65536 - fv) + s11 * fv) >>> 16;
                    p = (alo * (65536 - fu) + ahi * fu) >>> 16;
                    cm = (magn(p) << 16) / d;
                    if (p < 0) contrib = -longint'(cm);
                    else contrib = cm;
                    hit = 1;
                    res = acc + contrib;
                    if (res > SUM_MAX) res = SUM_MAX;
                    if (res < SUM_MIN) res = SUM_MIN;
                end
            end
        end else if (in_fov) begin
            res = scale_final(acc);
        end
        r.accum = res[47:0];
        r.in_fov = in_fov;
        r.hit = hit;
        return 1;
    endfunction

    function automatic voxel_item_t rand_item();
        voxel_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.col = 10'($urandom);
        it.row = 6'($urandom);
        it.sample = $urandom;
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        it.angle = 16'($urandom);
        it.accum = {$urandom, $urandom};
        return it;
    endfunction

    function automatic voxel_item_t make_voxel(logic [1:0] cmd, logic signed [31:0] x,
                                               logic signed [31:0] y, logic signed [31:0] z,
                                               logic [15:0] ang, logic signed [47:0] acc);
        voxel_item_t it;
        it = rand_item();
        it.cmd = cmd; it.x = x; it.y = y; it.z = z; it.angle = ang; it.accum = acc;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_coord(int span);
        int r;
        if ($urandom_range(0, 9) == 0) return $urandom;
        r = $urandom_range(0, 2 * span);
        return (r - span) * 65536 + $urandom_range(0, 65535);
    endfunction

    function automatic logic signed [47:0] rand_accum();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return SUM_MAX[47:0] - $urandom_range(0, 1000);
        if (r == 1) return SUM_MIN[47:0] + $urandom_range(0, 1000);
        if (r < 4) return {$urandom, $urandom};
        return {{16{1'b0}}, $urandom} - 48'sh0_8000_0000;
    endfunction

    // fill: 0 loads only missing taps, 1 forces max samples, 2 forces min samples
    task automatic queue_item(input voxel_item_t it, input int fill);
        voxel_sum_t r;
        voxel_item_t ld;
        bit has, reads;
        int base;
        int a [4];
        if (it.cmd == CMD_LOAD) begin
            proj[{it.row, it.col}] = it.sample;
            written[{it.row, it.col}] = 1'b1;
            pending_items.push_back(it);
            return;
        end
        has = predict_voxel(it, r, reads, base);
        if (reads) begin
            a = '{base, base + 1, base + DET_COLS, base + DET_COLS + 1};
            foreach (a[k]) begin
                if (!written[a[k]] || fill != 0) begin
                    ld = rand_item();
                    ld.cmd = CMD_LOAD;
                    ld.col = 10'(a[k] % DET_COLS);
                    ld.row = 6'(a[k] / DET_COLS);
                    if (fill == 1) ld.sample = 32'sh7FFF_FFFF;
                    if (fill == 2) ld.sample = 32'sh8000_0000;
                    queue_item(ld, 0);
                end
            end
            has = predict_voxel(it, r, reads, base);
        end
        pending_items.push_back(it);
        if (has) sums_due.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || sums_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [31:0] vals [7]);
        for (int i = 0; i < 7; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_index = CFG_IDX_W'(i);
            i_cfg_data = vals[i];
            geo[i] = vals[i];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_items(input int n, input int span);
        voxel_item_t it;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                it = rand_item();
                it.cmd = CMD_LOAD;
            end else if (r < 14) begin
                it = rand_item();
                it.cmd = CMD_UNUSED;
            end else begin
                it = make_voxel(r < 28 ? CMD_FINALIZE : CMD_BACKPROJECT, rand_coord(span),
                                rand_coord(span), rand_coord(span / 3), 16'($urandom),
                                rand_accum());
            end
            queue_item(it, 0);
        end
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Input side
    int in_gap = 0;
    bit in_rush = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    always @(negedge i_clk) begin
        voxel_item_t it;
        bit nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid && !in_took;
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() != 0) begin
                    it = pending_items.pop_front();
                    i_command <= it.cmd;
                    i_det_col <= it.col;
                    i_det_row <= it.row;
                    i_sample_value <= it.sample;
                    i_x_coord <= it.x;
                    i_y_coord <= it.y;
                    i_z_coord <= it.z;
                    i_view_angle <= it.angle;
                    i_accum_in <= it.accum;
                    nv = 1'b1;
                    if ($urandom_range(0, 39) == 0) in_rush = !in_rush;
                    in_gap = in_rush ? 0 : pick_gap();
                end
            end
            i_in_valid <= nv;
        end
    end

    // Output side
    int out_stall = 0;
    bit out_rush = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) out_rush = !out_rush;
            out_stall = out_rush ? 0 : pick_gap();
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        voxel_sum_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        in_took <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sums_due.size() == 0) begin
                flag_mismatch("unexpected transfer, accum_out", o_accum_out, 0);
            end else begin
                want = sums_due.pop_front();
                if (o_accum_out !== want.accum)
                    flag_mismatch("accum_out", o_accum_out, want.accum);
                if (o_inside_fov !== want.in_fov)
                    flag_mismatch("inside_fov", o_inside_fov, want.in_fov);
                if (o_tap_hit !== want.hit)
                    flag_mismatch("tap_hit", o_tap_hit, want.hit);
            end
        end
    end

    initial begin
        logic [31:0] geo_a [7];
        logic [31:0] geo_b [7];
        logic [31:0] geo_max [7];
        logic [31:0] geo_min [7];
        geo = '{32'd0, 32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0};
        geo_a = '{100 << 16, 150 << 16, 800 << 16, 1 << 16, (512 << 16) + 32768,
                  (32 << 16) + 32768, 32'hFFFF_FFFF};
        geo_b = '{100 << 16, 150 << 16, 800 << 16, 1 << 16, (512 << 16) + 32768,
                  (32 << 16) + 32768, 3200 << 16};
        geo_max = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        geo_min = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 3200 << 16};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry: field limit zero keeps every voxel outside
        random_items(12, 30);
        wait_idle();

        set_geometry(geo_a);
        begin
            voxel_item_t ld;
            ld = make_voxel(CMD_LOAD, 0, 0, 0, 0, 0);
            ld.col = 10'd0;
            ld.row = 6'd0;
            queue_item(ld, 0);
            ld = rand_item();
            ld.cmd = CMD_LOAD; ld.col = 10'h3FF; ld.row = 6'h3F; ld.sample = 32'sh8000_0000;
            queue_item(ld, 0);
        end
        queue_item(make_voxel(CMD_BACKPROJECT, 0, 0, 0, 16'd0, 48'sd0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 5 << 16, 3 << 16, 2 << 16, 16'd16384, 0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 5 << 16, 3 << 16, 2 << 16, 16'd32768, 0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 5 << 16, 3 << 16, 2 << 16, 16'd49152, 0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 5 << 16, 3 << 16, 2 << 16, 16'hFFFF, 0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 100 << 16, 0, 0, 16'd0, 48'sd77), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, (100 << 16) - (3 << 15), 0, 32'sh7FFF_FFFF,
                              16'd0, 48'sd5), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, (100 << 16) - (3 << 15), 0, 32'sh8000_0000,
                              16'd0, 48'sd5), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 3 << 16, 1 << 16, 50 << 16, 16'd900, 0), 0);
        queue_item(make_voxel(CMD_BACKPROJECT, 2 << 16, 1 << 16, 0, 16'd0, SUM_MAX[47:0]), 1);
        queue_item(make_voxel(CMD_BACKPROJECT, 2 << 16, 1 << 16, 0, 16'd0, SUM_MIN[47:0]), 2);
        queue_item(make_voxel(CMD_BACKPROJECT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0), 0);
        queue_item(make_voxel(CMD_FINALIZE, 1 << 16, 1 << 16, 0, 0, SUM_MAX[47:0]), 0);
        queue_item(make_voxel(CMD_FINALIZE, 1 << 16, 1 << 16, 0, 0, SUM_MIN[47:0]), 0);
        queue_item(make_voxel(CMD_FINALIZE, 0, 0, 0, 0, 48'sd0), 0);
        queue_item(make_voxel(CMD_FINALIZE, 0, 0, 0, 0, 48'sd123456789), 0);
        queue_item(make_voxel(CMD_FINALIZE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 48'sd9), 0);
        queue_item(make_voxel(CMD_UNUSED, 0, 0, 0, 0, 0), 0);
        wait_idle();

        set_geometry(geo_b);
        random_items(250, 40);
        wait_idle();

        set_geometry(geo_max);
        random_items(50, 30000);
        wait_idle();

        set_geometry(geo_min);
        random_items(50, 40);
        wait_idle();

        set_geometry(geo_a);
        random_items(40, 60);
        wait_idle();

        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cbvb_pkg.sv
rtl/cbvb_store.sv
rtl/cbvb_mul.sv
rtl/cbvb_div.sv
rtl/cone_beam_voxel_backprojector.sv
bench/tb_cone_beam_voxel_backprojector.sv
